>>> src/sia_pkg.sv
// shared constants and types for the stream id interval allocator
package sia_pkg;

  localparam int NUM_STREAMS = 64;
  localparam int MAX_ENTRIES = 256;
  localparam int TIME_BITS   = 32;

  localparam int ID_BITS    = 6;
  localparam int FIELD_TIME = 32;
  localparam int TW         = (TIME_BITS < FIELD_TIME) ? TIME_BITS : FIELD_TIME;
  localparam int ADDR_BITS  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);

  localparam logic [ID_BITS:0]    NUM_STREAMS_W = (ID_BITS + 1)'(NUM_STREAMS);
  localparam logic [ID_BITS-1:0]  LAST_OFF      = ID_BITS'(NUM_STREAMS - 1);
  localparam logic [CNT_BITS-1:0] MAX_COUNT     = CNT_BITS'(MAX_ENTRIES);

  localparam logic [1:0] ST_GRANT  = 2'd0;
  localparam logic [1:0] ST_ORDER  = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0] stream;
    logic [TW-1:0]      start;
    logic [TW-1:0]      finish;
  } entry_t;

  typedef struct packed {
    logic               clear;
    logic               mark;
    logic [ID_BITS-1:0] mark_idx;
    logic               shift;
  } cell_ctl_t;

endpackage

>>> src/sia_cell.sv
// one busy cell of the candidate id ring
module sia_cell (
  input  logic                        clk,
  input  sia_pkg::cell_ctl_t          ctl,
  input  logic [sia_pkg::ID_BITS-1:0] cell_pos,
  input  logic                        busy_in,
  output logic                        busy_out
);
  import sia_pkg::*;

  logic busy_r;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      busy_r <= 1'b0;
    end else if (ctl.mark && (ctl.mark_idx == cell_pos)) begin
      busy_r <= 1'b1;
    end else if (ctl.shift) begin
      busy_r <= busy_in;
    end
  end

  assign busy_out = busy_r;

endmodule

>>> src/sia_store.sv
// binding table memory, one write and one registered read port
module sia_store (
  input  logic                          clk,
  input  logic                          we,
  input  logic [sia_pkg::ADDR_BITS-1:0] waddr,
  input  sia_pkg::entry_t               wdata,
  input  logic                          re,
  input  logic [sia_pkg::ADDR_BITS-1:0] raddr,
  output sia_pkg::entry_t               rdata
);
  import sia_pkg::*;

  entry_t mem [MAX_ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/stream_id_interval_allocator.sv
// stream id allocator: first-fit search of ids against stored lifetime intervals
// states: prep, scan, search, done; a reversed interval or a full table goes from prep to done
// throughput: one request at a time; the table scan reads one stored binding per cycle
// and the candidate ring then checks one id per cycle, so these two loops set the rate
// a finished result sits in the output register while the next request is taken
// reset: synchronous active low clears the binding count and control; table contents stay
module stream_id_interval_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_produce_time,
  input  logic [31:0] in_consume_time,
  input  logic [5:0]  in_preferred_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_granted_id,
  output logic [31:0] out_lifetime
);
  import sia_pkg::*;

  // control states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [TW-1:0]       lo_r, hi_r;
  logic [ID_BITS-1:0]  pref_r;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] rd_addr_r;
  logic                rd_vld_r;
  logic [ID_BITS-1:0]  off_r;

  // pending result, held until the output register is free
  logic [1:0]            res_status_r;
  logic [ID_BITS-1:0]    res_id_r;
  logic [FIELD_TIME-1:0] res_life_r;

  // output register
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [ID_BITS-1:0]    out_id_r;
  logic [FIELD_TIME-1:0] out_life_r;

  logic               in_beat;
  logic               issue;
  logic               grant;
  logic               no_free;
  logic               overlap;
  logic [ID_BITS:0]   mark_sum;
  logic [ID_BITS:0]   grant_sum;
  logic [ID_BITS-1:0] mark_idx;
  logic [ID_BITS-1:0] grant_id;
  entry_t             rd_entry;
  entry_t             wr_entry;
  cell_ctl_t          cell_ctl;
  logic [NUM_STREAMS-1:0] busy;

  assign in_ready = (state_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;

  // table scan: one read per cycle while entries remain
  assign issue = (state_r == S_SCAN) && (rd_addr_r < count_r);

  // overlap of [lo, hi) with the stored [start, finish)
  assign overlap = (lo_r < rd_entry.finish) && (hi_r > rd_entry.start);

  // ring position of a stored id relative to the search start
  always_comb begin
    mark_sum = {1'b0, rd_entry.stream} + NUM_STREAMS_W - {1'b0, pref_r};
    if (mark_sum >= NUM_STREAMS_W) begin
      mark_sum = mark_sum - NUM_STREAMS_W;
    end
    mark_idx = mark_sum[ID_BITS-1:0];
  end

  // id under test in the search: start plus ring offset, wrapped
  always_comb begin
    grant_sum = {1'b0, pref_r} + {1'b0, off_r};
    if (grant_sum >= NUM_STREAMS_W) begin
      grant_sum = grant_sum - NUM_STREAMS_W;
    end
    grant_id = grant_sum[ID_BITS-1:0];
  end

  // cell 0 holds the busy flag of the current candidate
  assign grant   = (state_r == S_SEARCH) && !busy[0];
  assign no_free = (state_r == S_SEARCH) && busy[0] && (off_r == LAST_OFF);

  always_comb begin
    cell_ctl.clear    = in_beat;
    cell_ctl.mark     = rd_vld_r && overlap;
    cell_ctl.mark_idx = mark_idx;
    cell_ctl.shift    = (state_r == S_SEARCH);
  end

  // ring of busy cells, shifting toward cell 0 during the search
  for (genvar i = 0; i < NUM_STREAMS; i++) begin : g_cell
    sia_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .cell_pos (ID_BITS'(i)),
      .busy_in  (busy[(i + 1) % NUM_STREAMS]),
      .busy_out (busy[i])
    );
  end

  always_comb begin
    wr_entry.stream = grant_id;
    wr_entry.start  = lo_r;
    wr_entry.finish = hi_r;
  end

  sia_store u_store (
    .clk   (clk),
    .we    (grant),
    .waddr (count_r[ADDR_BITS-1:0]),
    .wdata (wr_entry),
    .re    (issue),
    .raddr (rd_addr_r[ADDR_BITS-1:0]),
    .rdata (rd_entry)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) state_nxt = S_PREP;
      end
      S_PREP: begin
        if ({1'b0, pref_r} < NUM_STREAMS_W) begin
          if ((hi_r < lo_r) || (count_r >= MAX_COUNT)) state_nxt = S_DONE;
          else state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !rd_vld_r) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (grant || no_free) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (grant) begin
        count_r <= count_r + 1'b1;
      end
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      lo_r   <= in_produce_time[TW-1:0];
      hi_r   <= in_consume_time[TW-1:0];
      pref_r <= in_preferred_id;
    end
    if (state_r == S_PREP) begin
      // reduce the start id modulo the stream count, one subtract a cycle
      if ({1'b0, pref_r} >= NUM_STREAMS_W) begin
        pref_r <= ID_BITS'({1'b0, pref_r} - NUM_STREAMS_W);
      end else if (hi_r < lo_r) begin
        res_status_r <= ST_ORDER;
        res_id_r     <= '0;
        res_life_r   <= '0;
      end else if (count_r >= MAX_COUNT) begin
        res_status_r <= ST_FULL;
        res_id_r     <= '0;
        res_life_r   <= '0;
      end
      rd_addr_r <= '0;
      off_r     <= '0;
    end
    if (issue) begin
      rd_addr_r <= rd_addr_r + 1'b1;
    end
    if (state_r == S_SEARCH) begin
      off_r <= off_r + 1'b1;
    end
    if (grant) begin
      res_status_r <= ST_GRANT;
      res_id_r     <= grant_id;
      res_life_r   <= FIELD_TIME'(hi_r - lo_r);
    end else if (no_free) begin
      res_status_r <= ST_NOFREE;
      res_id_r     <= '0;
      res_life_r   <= '0;
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_life_r   <= res_life_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_granted_id = out_id_r;
  assign out_lifetime   = out_life_r;

  // binding count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_COUNT)
    else $error("binding count beyond table size");

  // the count moves only on a grant, and then by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(grant) && (count_r == $past(count_r) + 1'b1)))
    else $error("binding count changed without a grant");

  // a refused request carries no id and no lifetime
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_GRANT)) |-> ((out_id_r == '0) && (out_life_r == '0)))
    else $error("refused result carries id or lifetime");

  // the ring search only runs after the table scan has drained
  a_search_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (!rd_vld_r && (rd_addr_r == count_r)))
    else $error("search started before the scan drained");

endmodule
